FILE: src/cpm_pkg.sv
package cpm_pkg;

    localparam int ID_DEPTH  = 8192;
    localparam int ANT_COUNT = 64;
    localparam int ID_W      = $clog2(ID_DEPTH);
    localparam int ANT_W     = $clog2(ANT_COUNT);

    // field widths of the item and result
    localparam int KIND_W   = 3;
    localparam int EID_W    = 13;
    localparam int ANTF_W   = 6;
    localparam int POL_W    = 3;
    localparam int MASK_W   = 64;
    localparam int STAT_W   = 3;
    localparam int COUNT_W  = 14;
    localparam int FILL_W   = 6;
    localparam int FILL_RESET = 36;

    // operation codes
    localparam logic [KIND_W-1:0] KIND_ADD     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_LOOKUP  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_REVERSE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FILL    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SLICE   = 3'd4;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK          = 3'd0;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND   = 3'd1;
    localparam logic [STAT_W-1:0] STAT_FILL_BUSY   = 3'd2;
    localparam logic [STAT_W-1:0] STAT_SLICE_EMPTY = 3'd3;
    localparam logic [STAT_W-1:0] STAT_MASK_HIGH   = 3'd4;
    localparam logic [STAT_W-1:0] STAT_SLICE_NONE  = 3'd5;

    // polarisation codes
    localparam logic [POL_W-1:0] POL_XX = 3'd0;
    localparam logic [POL_W-1:0] POL_XY = 3'd1;
    localparam logic [POL_W-1:0] POL_YX = 3'd2;
    localparam logic [POL_W-1:0] POL_YY = 3'd3;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [EID_W-1:0]  entry_id;
        logic [ANTF_W-1:0] first_antenna;
        logic [ANTF_W-1:0] second_antenna;
        logic [POL_W-1:0]  polarisation;
        logic [MASK_W-1:0] keep_mask;
    } item_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [EID_W-1:0]   id_out;
        logic [ANTF_W-1:0]  first_out;
        logic [ANTF_W-1:0]  second_out;
        logic [POL_W-1:0]   pol_out;
        logic [COUNT_W-1:0] entry_count;
        logic [EID_W-1:0]   highest_id;
        logic               lower_triangle;
        logic               upper_triangle;
    } result_t;

    typedef struct packed {
        logic              valid;
        logic [ANTF_W-1:0] first;
        logic [ANTF_W-1:0] second;
        logic [POL_W-1:0]  pol;
    } entry_t;

    typedef struct packed {
        logic            we;
        logic [ID_W-1:0] waddr;
        entry_t          wdata;
        logic [ID_W-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        logic             we;
        logic [ANT_W-1:0] waddr;
        logic [ANT_W-1:0] wdata;
        logic [ANT_W-1:0] raddr1;
        logic [ANT_W-1:0] raddr2;
    } rank_req_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD,
        ST_LOOKUP,
        ST_REVERSE,
        ST_FILL,
        ST_SCAN,
        ST_WRITE,
        ST_DONE
    } cpm_state_t;

    typedef enum logic [1:0] {
        FP_PRE,
        FP_DIAG,
        FP_POST
    } fill_phase_t;

endpackage

FILE: src/cpm_ram.sv
module cpm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: src/cpm_engine.sv
module cpm_engine
    import cpm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  item_t             item,
    output logic              item_stall,
    input  logic              cfg_valid,
    input  logic [FILL_W-1:0] cfg_data,
    output mem_req_t          mem,
    input  entry_t            rdata,
    output rank_req_t         rank,
    input  logic [ANT_W-1:0]  rank1,
    input  logic [ANT_W-1:0]  rank2,
    output logic              res_valid,
    output result_t           res,
    input  logic              res_take
);

    cpm_state_t        state_reg, state_next;
    item_t             item_reg, item_next;
    logic [FILL_W-1:0] fill_ant_reg;
    logic [ID_W:0]     vt_reg, vt_next;
    logic [ID_W-1:0]   top_reg, top_next;
    logic              upper_reg, upper_next;
    logic              lower_reg, lower_next;
    logic [ID_W:0]     addr_reg, addr_next;
    logic              rd_valid_reg, rd_valid_next;
    logic [ID_W-1:0]   rd_addr_reg, rd_addr_next;
    logic              s2_valid_reg, s2_valid_next;
    logic [ID_W-1:0]   s2_addr_reg, s2_addr_next;
    entry_t            s2_entry_reg, s2_entry_next;
    logic [ANTF_W-1:0] largest_reg, largest_next;
    logic [ID_W:0]     surv_reg, surv_next;
    logic [ANT_W:0]    run_reg, run_next;
    logic [ANTF_W-1:0] fa1_reg, fa1_next;
    logic [ANTF_W-1:0] fa2_reg, fa2_next;
    fill_phase_t       fph_reg, fph_next;
    logic              fsub_reg, fsub_next;
    logic [ANTF_W:0]   fn_reg, fn_next;
    logic [ID_W:0]     fid_reg, fid_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic [EID_W-1:0]  idout_reg, idout_next;
    logic [ANTF_W-1:0] fo_reg, fo_next;
    logic [ANTF_W-1:0] so_reg, so_next;
    logic [POL_W-1:0]  po_reg, po_next;

    logic              id_ok;
    logic              add_ok;
    logic [ANTF_W:0]   n_clamp;
    entry_t            target;
    logic              rev_match;
    logic              scan_end;
    logic              write_end;
    logic              fill_final;
    logic              fill_stop;
    logic              mask_high;
    logic              kept_rd;
    logic              kept_s2;
    logic [ANTF_W-1:0] cur_a1;
    logic [POL_W-1:0]  cur_pol;
    logic [ANTF_W-1:0] big_rd;

    assign id_ok   = 32'(item.entry_id) < 32'(ID_DEPTH);
    assign add_ok  = id_ok && (32'(item.first_antenna) < 32'(ANT_COUNT))
                     && (32'(item.second_antenna) < 32'(ANT_COUNT));
    assign n_clamp = (32'(fill_ant_reg) > 32'(ANT_COUNT)) ? (ANTF_W+1)'(ANT_COUNT)
                                                          : (ANTF_W+1)'(fill_ant_reg);

    assign target    = '{valid: 1'b1, first: item_reg.first_antenna,
                         second: item_reg.second_antenna, pol: item_reg.polarisation};
    assign rev_match = rd_valid_reg && (rdata == target);
    assign scan_end  = (32'(addr_reg) == 32'(ID_DEPTH)) && !rd_valid_reg;
    assign write_end = scan_end && !s2_valid_reg;

    // anything set above the largest antenna present
    assign mask_high = ((item_reg.keep_mask >> largest_reg) >> 1) != '0;
    assign kept_rd   = item_reg.keep_mask[rdata.first] && item_reg.keep_mask[rdata.second];
    assign kept_s2   = item_reg.keep_mask[s2_entry_reg.first]
                       && item_reg.keep_mask[s2_entry_reg.second];
    assign big_rd    = (rdata.first > rdata.second) ? rdata.first : rdata.second;

    assign fill_final = (fph_reg == FP_POST) && fsub_reg && (fa1_reg == fa2_reg)
                        && ((ANTF_W+1)'(fa2_reg) + (ANTF_W+1)'(1) == fn_reg);
    assign fill_stop  = 32'(fid_reg) == 32'(ID_DEPTH);

    always_comb
    begin
        case (fph_reg)
            FP_PRE:
            begin
                cur_a1  = fa1_reg;
                cur_pol = fsub_reg ? POL_YX : POL_XX;
            end
            FP_DIAG:
            begin
                cur_a1  = fa2_reg;
                cur_pol = POL_XX;
            end
            FP_POST:
            begin
                cur_a1  = fa1_reg;
                cur_pol = fsub_reg ? POL_YY : POL_XY;
            end
            default:
            begin
                cur_a1  = fa1_reg;
                cur_pol = POL_XX;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (32'(addr_reg) == 32'(ID_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    case (item.kind)
                        KIND_ADD:     state_next = add_ok ? ST_ADD : ST_DONE;
                        KIND_LOOKUP:  state_next = id_ok ? ST_LOOKUP : ST_DONE;
                        KIND_REVERSE: state_next = ST_REVERSE;
                        KIND_FILL:    state_next = (vt_reg != '0 || n_clamp == '0)
                                                   ? ST_DONE : ST_FILL;
                        KIND_SLICE:   state_next = (vt_reg == '0) ? ST_DONE : ST_SCAN;
                        default:      state_next = ST_DONE;
                    endcase
                end
            end
            ST_ADD:    state_next = ST_DONE;
            ST_LOOKUP: state_next = ST_DONE;
            ST_REVERSE:
            begin
                if (rev_match || scan_end)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_FILL:
            begin
                if (fill_stop || fill_final)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = (mask_high || surv_reg == '0) ? ST_DONE : ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (write_end)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and memory requests
    always_comb
    begin
        item_next     = item_reg;
        vt_next       = vt_reg;
        top_next      = top_reg;
        upper_next    = upper_reg;
        lower_next    = lower_reg;
        addr_next     = addr_reg;
        rd_valid_next = 1'b0;
        rd_addr_next  = rd_addr_reg;
        s2_valid_next = 1'b0;
        s2_addr_next  = rd_addr_reg;
        s2_entry_next = rdata;
        largest_next  = largest_reg;
        surv_next     = surv_reg;
        run_next      = run_reg;
        fa1_next      = fa1_reg;
        fa2_next      = fa2_reg;
        fph_next      = fph_reg;
        fsub_next     = fsub_reg;
        fn_next       = fn_reg;
        fid_next      = fid_reg;
        status_next   = status_reg;
        idout_next    = idout_reg;
        fo_next       = fo_reg;
        so_next       = so_reg;
        po_next       = po_reg;

        mem.we     = 1'b0;
        mem.waddr  = addr_reg[ID_W-1:0];
        mem.wdata  = '0;
        mem.raddr  = addr_reg[ID_W-1:0];
        rank.we     = 1'b0;
        rank.waddr  = addr_reg[ANT_W-1:0];
        rank.wdata  = run_reg[ANT_W-1:0];
        rank.raddr1 = ANT_W'(rdata.first);
        rank.raddr2 = ANT_W'(rdata.second);

        case (state_reg)
            ST_CLEAR:
            begin
                mem.we    = 1'b1;
                addr_next = addr_reg + 1'b1;
            end
            ST_IDLE:
            begin
                mem.raddr = ID_W'(item.entry_id);
                if (item_valid)
                begin
                    item_next    = item;
                    status_next  = STAT_OK;
                    idout_next   = '0;
                    fo_next      = '0;
                    so_next      = '0;
                    po_next      = '0;
                    addr_next    = '0;
                    largest_next = '0;
                    surv_next    = '0;
                    run_next     = '0;
                    fa1_next     = '0;
                    fa2_next     = '0;
                    fph_next     = FP_DIAG;
                    fsub_next    = 1'b0;
                    fn_next      = n_clamp;
                    fid_next     = (ID_W+1)'(1);
                    case (item.kind)
                        KIND_LOOKUP:
                        begin
                            if (!id_ok)
                            begin
                                status_next = STAT_NOT_FOUND;
                            end
                        end
                        KIND_REVERSE: status_next = STAT_NOT_FOUND;
                        KIND_FILL:
                        begin
                            if (vt_reg != '0)
                            begin
                                status_next = STAT_FILL_BUSY;
                            end
                        end
                        KIND_SLICE:
                        begin
                            if (vt_reg == '0)
                            begin
                                status_next = STAT_SLICE_EMPTY;
                            end
                        end
                        default: status_next = STAT_OK;
                    endcase
                end
            end
            ST_ADD:
            begin
                mem.we    = 1'b1;
                mem.waddr = ID_W'(item_reg.entry_id);
                mem.wdata = target;
                if (!rdata.valid)
                begin
                    vt_next = vt_reg + 1'b1;
                end
                if (item_reg.first_antenna > item_reg.second_antenna)
                begin
                    upper_next = 1'b0;
                end
                if (item_reg.second_antenna > item_reg.first_antenna)
                begin
                    lower_next = 1'b0;
                end
                if (ID_W'(item_reg.entry_id) > top_reg)
                begin
                    top_next = ID_W'(item_reg.entry_id);
                end
            end
            ST_LOOKUP:
            begin
                if (rdata.valid)
                begin
                    fo_next = rdata.first;
                    so_next = rdata.second;
                    po_next = rdata.pol;
                end
                else
                begin
                    status_next = STAT_NOT_FOUND;
                end
            end
            ST_REVERSE:
            begin
                if (32'(addr_reg) < 32'(ID_DEPTH))
                begin
                    addr_next     = addr_reg + 1'b1;
                    rd_valid_next = 1'b1;
                    rd_addr_next  = addr_reg[ID_W-1:0];
                end
                if (rev_match)
                begin
                    status_next = STAT_OK;
                    idout_next  = EID_W'(rd_addr_reg);
                    fo_next     = item_reg.first_antenna;
                    so_next     = item_reg.second_antenna;
                    po_next     = item_reg.polarisation;
                end
            end
            ST_FILL:
            begin
                if (!fill_stop)
                begin
                    mem.we    = 1'b1;
                    mem.waddr = fid_reg[ID_W-1:0];
                    mem.wdata = '{valid: 1'b1, first: cur_a1, second: fa2_reg, pol: cur_pol};
                    vt_next   = vt_reg + 1'b1;
                    top_next  = fid_reg[ID_W-1:0];
                    fid_next  = fid_reg + 1'b1;
                    if (cur_a1 < fa2_reg)
                    begin
                        lower_next = 1'b0;
                    end
                    case (fph_reg)
                        FP_PRE:
                        begin
                            fsub_next = !fsub_reg;
                            if (fsub_reg)
                            begin
                                fa1_next = fa1_reg + 1'b1;
                                if (fa1_reg + 1'b1 == fa2_reg)
                                begin
                                    fph_next = FP_DIAG;
                                end
                            end
                        end
                        FP_DIAG:
                        begin
                            fph_next  = FP_POST;
                            fa1_next  = '0;
                            fsub_next = 1'b0;
                        end
                        FP_POST:
                        begin
                            fsub_next = !fsub_reg;
                            if (fsub_reg)
                            begin
                                if (fa1_reg == fa2_reg)
                                begin
                                    fa2_next = fa2_reg + 1'b1;
                                    fa1_next = '0;
                                    fph_next = FP_PRE;
                                end
                                else
                                begin
                                    fa1_next = fa1_reg + 1'b1;
                                end
                            end
                        end
                        default: fph_next = FP_DIAG;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (32'(addr_reg) < 32'(ID_DEPTH))
                begin
                    addr_next     = addr_reg + 1'b1;
                    rd_valid_next = 1'b1;
                    rd_addr_next  = addr_reg[ID_W-1:0];
                end
                // rank table built while the scan address is below ANT_COUNT
                if (32'(addr_reg) < 32'(ANT_COUNT))
                begin
                    rank.we  = 1'b1;
                    run_next = run_reg + (ANT_W+1)'(item_reg.keep_mask[addr_reg[ANT_W-1:0]]);
                end
                if (rd_valid_reg && rdata.valid)
                begin
                    if (big_rd > largest_reg)
                    begin
                        largest_next = big_rd;
                    end
                    if (kept_rd)
                    begin
                        surv_next = surv_reg + 1'b1;
                    end
                end
                if (scan_end)
                begin
                    addr_next = '0;
                    if (mask_high)
                    begin
                        status_next = STAT_MASK_HIGH;
                    end
                    else if (surv_reg == '0)
                    begin
                        status_next = STAT_SLICE_NONE;
                    end
                    else
                    begin
                        top_next = '0;
                    end
                end
            end
            ST_WRITE:
            begin
                if (32'(addr_reg) < 32'(ID_DEPTH))
                begin
                    addr_next     = addr_reg + 1'b1;
                    rd_valid_next = 1'b1;
                    rd_addr_next  = addr_reg[ID_W-1:0];
                end
                s2_valid_next = rd_valid_reg;
                if (s2_valid_reg)
                begin
                    mem.we    = 1'b1;
                    mem.waddr = s2_addr_reg;
                    if (s2_entry_reg.valid && kept_s2)
                    begin
                        mem.wdata = '{valid: 1'b1, first: ANTF_W'(rank1),
                                      second: ANTF_W'(rank2), pol: s2_entry_reg.pol};
                        top_next  = s2_addr_reg;
                    end
                end
                if (write_end)
                begin
                    vt_next = surv_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            fill_ant_reg <= FILL_W'(FILL_RESET);
            vt_reg       <= '0;
            top_reg      <= '0;
            upper_reg    <= 1'b1;
            lower_reg    <= 1'b1;
            addr_reg     <= '0;
            rd_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            vt_reg       <= vt_next;
            top_reg      <= top_next;
            upper_reg    <= upper_next;
            lower_reg    <= lower_next;
            addr_reg     <= addr_next;
            rd_valid_reg <= rd_valid_next;
            s2_valid_reg <= s2_valid_next;
            if (cfg_valid)
            begin
                fill_ant_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        rd_addr_reg  <= rd_addr_next;
        s2_addr_reg  <= s2_addr_next;
        s2_entry_reg <= s2_entry_next;
        largest_reg  <= largest_next;
        surv_reg     <= surv_next;
        run_reg      <= run_next;
        fa1_reg      <= fa1_next;
        fa2_reg      <= fa2_next;
        fph_reg      <= fph_next;
        fsub_reg     <= fsub_next;
        fn_reg       <= fn_next;
        fid_reg      <= fid_next;
        status_reg   <= status_next;
        idout_reg    <= idout_next;
        fo_reg       <= fo_next;
        so_reg       <= so_next;
        po_reg       <= po_next;
    end

    assign item_stall = state_reg != ST_IDLE;
    assign res_valid  = state_reg == ST_DONE;

    always_comb
    begin
        res.status         = status_reg;
        res.id_out         = idout_reg;
        res.first_out      = fo_reg;
        res.second_out     = so_reg;
        res.pol_out        = po_reg;
        res.entry_count    = COUNT_W'(vt_reg);
        res.highest_id     = (vt_reg != '0) ? EID_W'(top_reg) : '0;
        res.lower_triangle = lower_reg && (vt_reg != '0);
        res.upper_triangle = upper_reg && (vt_reg != '0);
    end

endmodule

FILE: src/correlation_product_map_unit.sv
// correlation product map: a table of ID_DEPTH entries, each holding an antenna
// pair and a polarisation code, kept in one synchronous memory with a registered
// read. every item returns exactly one result with a status, any looked-up
// entry and a summary of the table (count, highest id, triangle flags).
// after reset a clearing pass writes every entry once, and no item is taken
// meanwhile; configuration writes are taken at all times.
// add makes one read-modify-write of the memory and lookup by id one read;
// reverse lookup walks the memory one entry a cycle and stops early when a
// match is found; fill writes one entry a cycle for n antennas, stopping at
// the end of the table; slice takes two full memory passes (scan, then read,
// rank lookup and write back), or only the scan when the scan rejects it.
// one item is in work at a time; the result register frees the engine so the
// next item can be taken while an earlier result still waits to be taken
module correlation_product_map_unit
    import cpm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  item_t             item,
    output logic              result_valid,
    input  logic              result_stall,
    output result_t           result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [FILL_W-1:0] cfg_data
);

    mem_req_t         mem;
    entry_t           rdata;
    rank_req_t        rank;
    logic [ANT_W-1:0] rank1;
    logic [ANT_W-1:0] rank2;
    logic             res_valid;
    result_t          res;
    logic             res_take;
    logic             result_valid_reg, result_valid_next;
    result_t          result_reg;

    // register file is always writable
    assign cfg_ready = 1'b1;

    // entry table
    cpm_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (ID_DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (mem.we),
        .waddr (mem.waddr),
        .wdata (mem.wdata),
        .raddr (mem.raddr),
        .rdata (rdata)
    );

    // rank of each antenna in the keep mask, one copy per antenna of the pair
    cpm_ram #(
        .WIDTH (ANT_W),
        .DEPTH (ANT_COUNT)
    ) u_rank_ram1 (
        .clk   (clk),
        .we    (rank.we),
        .waddr (rank.waddr),
        .wdata (rank.wdata),
        .raddr (rank.raddr1),
        .rdata (rank1)
    );

    cpm_ram #(
        .WIDTH (ANT_W),
        .DEPTH (ANT_COUNT)
    ) u_rank_ram2 (
        .clk   (clk),
        .we    (rank.we),
        .waddr (rank.waddr),
        .wdata (rank.wdata),
        .raddr (rank.raddr2),
        .rdata (rank2)
    );

    cpm_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_stall (item_stall),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .mem        (mem),
        .rdata      (rdata),
        .rank       (rank),
        .rank1      (rank1),
        .rank2      (rank2),
        .res_valid  (res_valid),
        .res        (res),
        .res_take   (res_take)
    );

    // result register: loads when empty or being drained by a transfer
    assign res_take = res_valid && (!result_valid_reg || !result_stall);

    always_comb
    begin
        if (res_take)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_stall)
        begin
            result_valid_next = result_valid_reg;
        end
        else
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            result_reg <= res;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

FILE: src/cpm_checker.sv
module cpm_checker
    import cpm_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    result_valid,
    input logic    result_stall,
    input result_t result
);

    // a held result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed");

    // failed operations report no entry fields
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status != STAT_OK |->
            result.id_out == '0 && result.first_out == '0
            && result.second_out == '0 && result.pol_out == '0)
        else $error("entry fields set on failed operation");

    // empty table shows no summary
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.entry_count == '0 |->
            result.highest_id == '0 && !result.lower_triangle && !result.upper_triangle)
        else $error("summary set on empty table");

    // status stays within the defined codes
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.status <= STAT_SLICE_NONE)
        else $error("undefined status code");

endmodule

bind correlation_product_map_unit cpm_checker u_cpm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
